FILE: rtl/hll_pkg.sv
// Shared types and constants of the HyperLogLog sketch.
package hll_pkg;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_MERGE = 2'd1,
        OP_COUNT = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] hash;
        logic [13:0] merge_index;
        logic [4:0]  merge_rank;
    } t_req;

    typedef struct packed {
        logic [31:0] estimate;
        logic        overflow;
        logic        updated;
    } t_res;

    // classified command passed from front to back
    typedef struct packed {
        t_op        op;
        logic [4:0] rank;
        logic       idx_ok;
    } t_cmd;

    localparam int CFG_IB_MIN   = 4;
    localparam int CFG_IB_RESET = 14;
    localparam int RANK_FRAC    = 29;  // fraction bits of the harmonic sum

    localparam logic [23:0] ALPHA4_Q24 = 24'd11291066;
    localparam logic [23:0] ALPHA5_Q24 = 24'd11693719;
    localparam logic [23:0] ALPHA6_Q24 = 24'd11895046;
    localparam logic [25:0] LN2_Q26    = 26'd46516319;

    localparam logic [6:0] DIV_STEPS_ALPHA = 7'd64;
    localparam logic [6:0] DIV_STEPS_EST   = 7'd93;
    localparam logic [5:0] LOG_K_TOP       = 6'd56;
    localparam logic [5:0] LARGE_WHOLE     = 6'd56;

endpackage

FILE: rtl/hyperloglog_sketch_core.sv
// Top level of the HyperLogLog cardinality sketch.
//
// Request channel: i_in_valid / o_in_stall / i_in_req (func, hash, merge_index,
// merge_rank). Result channel: o_out_valid / i_out_stall / o_out_res, one
// result for every request, in request order, unless an index_bits write cuts one short.
// A two-entry command queue sits between the decode front and the store back,
// so requests keep arriving while a result waits in the output register.
// Add and merge: rank store read, then compare and write back.
// Count with a clean cache: answered from the cached estimate. Count after a
// change: a walk of the store, the divider (alpha division only for index_bits
// above 6, then the estimate division), and the logarithm where needed.
// Clear: one pass over all 2^MAX_INDEX_BITS entries of the store.
// Reset and every write to index_bits start the same clearing pass, during
// which o_in_stall is high; the index_bits write value is clamped to
// [4, MAX_INDEX_BITS]. A stalled result simply holds in the output register;
// the back end then waits once its next result is ready, and the front queue
// fills and raises o_in_stall.
module hyperloglog_sketch_core import hll_pkg::*; #(
    parameter int MAX_INDEX_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_req       i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_res       o_out_res,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata
);

    localparam int IB_W     = $clog2(MAX_INDEX_BITS + 1);
    localparam int IB_RESET = (CFG_IB_RESET > MAX_INDEX_BITS) ? MAX_INDEX_BITS : CFG_IB_RESET;

    logic [IB_W-1:0]           r_index_bits;
    logic [IB_W-1:0]           n_index_bits;
    logic                      w_clearing;
    logic                      w_pop;
    logic                      w_q_valid;
    t_cmd                      w_q_cmd;
    logic [MAX_INDEX_BITS-1:0] w_q_idx;

    // clamp the written register count exponent
    always_comb begin
        if (int'(i_cfg_wdata) < CFG_IB_MIN) begin
            n_index_bits = IB_W'(CFG_IB_MIN);
        end else if (int'(i_cfg_wdata) > MAX_INDEX_BITS) begin
            n_index_bits = IB_W'(MAX_INDEX_BITS);
        end else begin
            n_index_bits = IB_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= IB_W'(IB_RESET);
        end else if (i_cfg_we) begin
            r_index_bits <= n_index_bits;
        end
    end

    hll_front #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_index_bits (r_index_bits),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_req        (i_in_req),
        .i_clearing   (w_clearing),
        .i_pop        (w_pop),
        .o_q_valid    (w_q_valid),
        .o_q_cmd      (w_q_cmd),
        .o_q_idx      (w_q_idx)
    );

    // a register write restarts the sketch through the clearing pass
    hll_back #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_index_bits (r_index_bits),
        .i_clear_req  (i_cfg_we),
        .i_q_valid    (w_q_valid),
        .i_q_cmd      (w_q_cmd),
        .i_q_idx      (w_q_idx),
        .o_pop        (w_pop),
        .o_clearing   (w_clearing),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_res    (o_out_res)
    );

    // a config write holds off requests for the clearing pass
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("request accepted right after a config write");

    // overflow is only ever flagged on a saturated estimate
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_res.overflow) |-> (o_out_res.estimate == 32'hFFFF_FFFF))
        else $error("overflow without saturated estimate");

    // a raised rank never comes with an estimate
    a_upd_no_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_res.updated) |-> (o_out_res.estimate == 32'd0))
        else $error("update result carries an estimate");

    // the queue is never popped while it is empty
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty command queue");

endmodule

FILE: rtl/hll_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hll_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/hll_front.sv
// Front end: accepts requests, decodes index and rank, two-entry command queue.
module hll_front import hll_pkg::*; #(
    parameter int MAX_INDEX_BITS = 14,
    localparam int IB_W = $clog2(MAX_INDEX_BITS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [IB_W-1:0]           i_index_bits,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  t_req                      i_req,
    input  logic                      i_clearing,
    input  logic                      i_pop,
    output logic                      o_q_valid,
    output t_cmd                      o_q_cmd,
    output logic [MAX_INDEX_BITS-1:0] o_q_idx
);

    logic [5:0]  w_tail_bits;
    logic [31:0] w_add_idx;
    logic [31:0] w_mrg_idx;
    logic [5:0]  w_tz;
    logic [5:0]  w_tz_cap;
    logic [5:0]  w_mrg_cap;
    t_cmd        w_cmd;
    logic [MAX_INDEX_BITS-1:0] w_idx;
    logic        w_push;

    t_cmd                      r_q_cmd [2];
    logic [MAX_INDEX_BITS-1:0] r_q_idx [2];
    logic                      r_wp;
    logic                      r_rp;
    logic [1:0]                r_cnt;

    assign w_tail_bits = 6'd32 - 6'(i_index_bits);
    assign w_add_idx   = i_req.hash >> w_tail_bits;
    assign w_mrg_idx   = 32'(i_req.merge_index);
    assign w_mrg_cap   = w_tail_bits + 6'd1;

    // trailing zero count of the hash
    always_comb begin
        w_tz = 6'd32;
        for (int i = 31; i >= 0; i--) begin
            if (i_req.hash[i]) begin
                w_tz = 6'(i);
            end
        end
    end

    assign w_tz_cap = (w_tz > w_tail_bits) ? w_tail_bits : w_tz;

    always_comb begin
        w_cmd.op     = t_op'(i_req.func);
        w_cmd.rank   = 5'd0;
        w_cmd.idx_ok = 1'b0;
        w_idx        = '0;
        case (w_cmd.op)
            OP_ADD: begin
                w_cmd.rank   = 5'(w_tz_cap + 6'd1);
                w_cmd.idx_ok = 1'b1;
                w_idx        = w_add_idx[MAX_INDEX_BITS-1:0];
            end
            OP_MERGE: begin
                w_cmd.rank   = ({1'b0, i_req.merge_rank} > w_mrg_cap) ?
                               5'(w_mrg_cap) : i_req.merge_rank;
                w_cmd.idx_ok = ((w_mrg_idx >> i_index_bits) == 32'd0);
                w_idx        = w_mrg_idx[MAX_INDEX_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_stall = (r_cnt == 2'd2) || i_clearing;
    assign w_push  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q_cmd[r_wp] <= w_cmd;
                r_q_idx[r_wp] <= w_idx;
                r_wp          <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q_cmd[r_rp];
    assign o_q_idx   = r_q_idx[r_rp];

endmodule

FILE: rtl/hll_back.sv
// Back end: rank store, clearing pass, estimate sequencer and result register.
module hll_back import hll_pkg::*; #(
    parameter int MAX_INDEX_BITS = 14,
    localparam int IB_W = $clog2(MAX_INDEX_BITS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [IB_W-1:0]           i_index_bits,
    input  logic                      i_clear_req,
    input  logic                      i_q_valid,
    input  t_cmd                      i_q_cmd,
    input  logic [MAX_INDEX_BITS-1:0] i_q_idx,
    output logic                      o_pop,
    output logic                      o_clearing,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_res                      o_out_res
);

    localparam int IDX_W = MAX_INDEX_BITS;
    localparam int SUM_W = IDX_W + RANK_FRAC + 1;
    localparam int ZW    = IDX_W + 1;

    typedef enum logic [16:0] {
        S_CLR   = 17'h00001,
        S_IDLE  = 17'h00002,
        S_UPD   = 17'h00004,
        S_WALK  = 17'h00008,
        S_TAIL  = 17'h00010,
        S_DIV   = 17'h00020,
        S_ESET  = 17'h00040,
        S_RANGE = 17'h00080,
        S_LNORM = 17'h00100,
        S_LSQ   = 17'h00200,
        S_LSTEP = 17'h00400,
        S_LND   = 17'h00800,
        S_LNLO  = 17'h01000,
        S_LNHI  = 17'h02000,
        S_LNACC = 17'h04000,
        S_FIN   = 17'h08000,
        S_EMIT  = 17'h10000
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_addr;
    logic               r_clr_item;
    logic               r_acc_en;
    logic [31:0]        r_cache;
    logic               r_cache_valid;
    logic               r_out_valid;
    t_res               r_out_res;
    t_res               r_res;
    logic [IDX_W-1:0]   r_idx;
    logic [4:0]         r_rank;
    logic               r_idx_ok;
    logic [SUM_W-1:0]   r_sum;
    logic [ZW-1:0]      r_zeros;
    logic [23:0]        r_alpha;
    logic [63:0]        r_dd;
    logic [SUM_W-1:0]   r_dv;
    logic [SUM_W-1:0]   r_rem;
    logic [63:0]        r_q;
    logic [6:0]         r_dcnt;
    logic [6:0]         r_dsteps;
    logic               r_div_alpha;
    logic [56:0]        r_lv;
    logic [5:0]         r_k;
    logic [5:0]         r_whole;
    logic               r_large;
    logic [30:0]        r_y;
    logic [29:0]        r_frac;
    logic [4:0]         r_lcnt;
    logic [35:0]        r_d;
    logic [61:0]        r_prod;
    logic [43:0]        r_lnacc;
    logic [39:0]        r_fin_val;

    logic [4:0]         w_rdata;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [4:0]         w_wdata;
    logic [IDX_W-1:0]   w_raddr;
    logic [IDX_W:0]     w_m;
    logic [IDX_W-1:0]   w_last;
    logic               w_upd;
    logic               w_out_free;
    logic               w_fin;
    t_res               w_fin_res;
    logic [SUM_W:0]     w_trial;
    logic [SUM_W:0]     w_diff;
    logic               w_ge;
    logic [SUM_W-1:0]   w_rem_n;
    logic [63:0]        w_q_n;
    logic [SUM_W-1:0]   w_den;
    logic [63:0]        w_small_lim;
    logic [60:0]        w_e30;
    logic [31:0]        w_p;
    logic [30:0]        w_mul_a;
    logic [30:0]        w_mul_b;
    logic [62:0]        w_ln_full;
    logic [30:0]        w_ln;
    logic [63:0]        w_ln_small;
    logic [31:0]        w_sat;

    hll_ram #(
        .WIDTH (5),
        .DEPTH (1 << IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_m    = (IDX_W+1)'(1) << i_index_bits;
    assign w_last = w_m[IDX_W-1:0] - IDX_W'(1);

    assign o_pop      = (r_state == S_IDLE) && i_q_valid && !i_clear_req;
    assign o_clearing = (r_state == S_CLR);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_upd   = r_idx_ok && (r_rank > w_rdata);
    assign w_we    = (r_state == S_CLR) || ((r_state == S_UPD) && w_upd);
    assign w_waddr = (r_state == S_CLR) ? r_addr : r_idx;
    assign w_wdata = (r_state == S_CLR) ? 5'd0 : r_rank;
    assign w_raddr = (r_state == S_WALK) ? r_addr : i_q_idx;

    // restoring divider, one quotient bit a cycle
    assign w_trial = {r_rem, r_dd[63]};
    assign w_diff  = w_trial - {1'b0, r_dv};
    assign w_ge    = (w_trial >= {1'b0, r_dv});
    assign w_rem_n = w_ge ? w_diff[SUM_W-1:0] : w_trial[SUM_W-1:0];
    assign w_q_n   = {r_q[62:0], w_ge};
    assign w_den   = (SUM_W'(10000) << i_index_bits) + SUM_W'(10790);

    assign w_small_lim = 64'(5) << (6'(i_index_bits) + 6'd23);
    assign w_e30       = {r_q[55:0], 5'd0} - {4'd0, r_q[55:0], 1'b0};

    assign w_p = r_prod[61:30];

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_LSQ: begin
                w_mul_a = r_y;
                w_mul_b = r_y;
            end
            S_LNLO: begin
                w_mul_a = 31'(r_d[17:0]);
                w_mul_b = 31'(LN2_Q26);
            end
            S_LNHI: begin
                w_mul_a = 31'(r_d[35:18]);
                w_mul_b = 31'(LN2_Q26);
            end
            default: begin
            end
        endcase
    end

    assign w_ln_full  = 63'(r_lnacc) + (63'(r_prod) << 18);
    assign w_ln       = w_ln_full[62:32];
    assign w_ln_small = (64'(w_ln) << i_index_bits) >> 24;
    assign w_sat      = (r_fin_val[39:32] != 8'd0) ? 32'hFFFF_FFFF : r_fin_val[31:0];

    always_comb begin
        w_fin     = 1'b0;
        w_fin_res = '0;
        case (r_state)
            S_IDLE: begin
                if (o_pop && i_q_cmd.op == OP_COUNT && r_cache_valid) begin
                    w_fin              = 1'b1;
                    w_fin_res.estimate = r_cache;
                    w_fin_res.overflow = (r_cache == 32'hFFFF_FFFF);
                end
            end
            S_UPD: begin
                w_fin             = 1'b1;
                w_fin_res.updated = w_upd;
            end
            S_CLR: begin
                w_fin = (r_addr == '1) && r_clr_item;
            end
            S_FIN: begin
                w_fin              = 1'b1;
                w_fin_res.estimate = w_sat;
                w_fin_res.overflow = (w_sat == 32'hFFFF_FFFF);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_addr        <= '0;
            r_clr_item    <= 1'b0;
            r_acc_en      <= 1'b0;
            r_cache       <= '0;
            r_cache_valid <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_acc_en <= (r_state == S_WALK);
            r_prod   <= {31'd0, w_mul_a} * {31'd0, w_mul_b};
            if (r_acc_en) begin
                r_sum   <= r_sum + (SUM_W'(1) << (5'(RANK_FRAC) - w_rdata));
                r_zeros <= r_zeros + ZW'(w_rdata == 5'd0);
            end

            case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + IDX_W'(1);
                    if (r_addr == '1) begin
                        r_clr_item <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_idx    <= i_q_idx;
                        r_rank   <= i_q_cmd.rank;
                        r_idx_ok <= i_q_cmd.idx_ok;
                        case (i_q_cmd.op)
                            OP_ADD, OP_MERGE: begin
                                r_state <= S_UPD;
                            end
                            OP_COUNT: begin
                                if (!r_cache_valid) begin
                                    r_addr  <= '0;
                                    r_sum   <= '0;
                                    r_zeros <= '0;
                                    r_state <= S_WALK;
                                end
                            end
                            OP_CLEAR: begin
                                r_addr        <= '0;
                                r_clr_item    <= 1'b1;
                                r_cache       <= '0;
                                r_cache_valid <= 1'b1;
                                r_state       <= S_CLR;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_UPD: begin
                    if (w_upd) begin
                        r_cache_valid <= 1'b0;
                    end
                end
                S_WALK: begin
                    r_addr <= r_addr + IDX_W'(1);
                    if (r_addr == w_last) begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    case (i_index_bits)
                        IB_W'(4): begin
                            r_alpha <= ALPHA4_Q24;
                            r_state <= S_ESET;
                        end
                        IB_W'(5): begin
                            r_alpha <= ALPHA5_Q24;
                            r_state <= S_ESET;
                        end
                        IB_W'(6): begin
                            r_alpha <= ALPHA6_Q24;
                            r_state <= S_ESET;
                        end
                        default: begin
                            r_dd        <= 64'(7213) << (6'(i_index_bits) + 6'd24);
                            r_dv        <= w_den;
                            r_rem       <= '0;
                            r_q         <= '0;
                            r_dcnt      <= '0;
                            r_dsteps    <= DIV_STEPS_ALPHA;
                            r_div_alpha <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    endcase
                end
                S_ESET: begin
                    r_dd        <= 64'(r_alpha) << {i_index_bits, 1'b0};
                    r_dv        <= r_sum;
                    r_rem       <= '0;
                    r_q         <= '0;
                    r_dcnt      <= '0;
                    r_dsteps    <= DIV_STEPS_EST;
                    r_div_alpha <= 1'b0;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    r_dd   <= {r_dd[62:0], 1'b0};
                    r_rem  <= w_rem_n;
                    r_q    <= w_q_n;
                    r_dcnt <= r_dcnt + 7'd1;
                    if (r_dcnt == r_dsteps - 7'd1) begin
                        if (r_div_alpha) begin
                            r_alpha <= w_q_n[23:0];
                            r_state <= S_ESET;
                        end else begin
                            r_state <= S_RANGE;
                        end
                    end
                end
                S_RANGE: begin
                    r_k <= LOG_K_TOP;
                    if (r_q <= w_small_lim) begin
                        if (r_zeros != '0) begin
                            r_lv    <= 57'(r_zeros);
                            r_whole <= 6'(i_index_bits);
                            r_large <= 1'b0;
                            r_state <= S_LNORM;
                        end else begin
                            r_fin_val <= 40'(r_q[55:24]);
                            r_state   <= S_FIN;
                        end
                    end else if (r_q[63:56] != 8'd0) begin
                        r_fin_val <= 40'h01_0000_0000;
                        r_state   <= S_FIN;
                    end else if (w_e30 > (61'(1) << 56)) begin
                        r_lv    <= (57'(1) << 56) - {1'b0, r_q[55:0]};
                        r_whole <= LARGE_WHOLE;
                        r_large <= 1'b1;
                        r_state <= S_LNORM;
                    end else begin
                        r_fin_val <= 40'(r_q[55:24]);
                        r_state   <= S_FIN;
                    end
                end
                S_LNORM: begin
                    if (r_lv[56]) begin
                        r_y     <= r_lv[56:26];
                        r_frac  <= '0;
                        r_lcnt  <= '0;
                        r_state <= S_LSQ;
                    end else begin
                        r_lv <= {r_lv[55:0], 1'b0};
                        r_k  <= r_k - 6'd1;
                    end
                end
                S_LSQ: begin
                    r_state <= S_LSTEP;
                end
                S_LSTEP: begin
                    r_frac <= {r_frac[28:0], w_p[31]};
                    r_y    <= w_p[31] ? w_p[31:1] : w_p[30:0];
                    r_lcnt <= r_lcnt + 5'd1;
                    r_state <= (r_lcnt == 5'd29) ? S_LND : S_LSQ;
                end
                S_LND: begin
                    r_d     <= {r_whole, 30'd0} - {r_k, r_frac};
                    r_state <= S_LNLO;
                end
                S_LNLO: begin
                    r_state <= S_LNHI;
                end
                S_LNHI: begin
                    r_lnacc <= r_prod[43:0];
                    r_state <= S_LNACC;
                end
                S_LNACC: begin
                    r_fin_val <= r_large ? (40'(w_ln) << 8) : w_ln_small[39:0];
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    r_cache       <= w_sat;
                    r_cache_valid <= 1'b1;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_res   <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_fin) begin
                if (w_out_free) begin
                    r_out_valid <= 1'b1;
                    r_out_res   <= w_fin_res;
                    r_state     <= S_IDLE;
                end else begin
                    r_res   <= w_fin_res;
                    r_state <= S_EMIT;
                end
            end

            if (i_clear_req) begin
                r_state       <= S_CLR;
                r_addr        <= '0;
                r_clr_item    <= 1'b0;
                r_cache       <= '0;
                r_cache_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule
